@@ rtl/belt_pkg.sv @@
package belt_pkg;

    localparam int NUM_KEY_WORDS = 8;
    localparam int KEY_IDX_W     = $clog2(NUM_KEY_WORDS);
    localparam int NUM_ROUNDS    = 8;
    localparam int LEVELS        = 4;                       // G levels per round
    localparam int NUM_STAGES    = NUM_ROUNDS * LEVELS;
    localparam int WORD_W        = 32;

    localparam logic OP_DECRYPT = 1'b0;
    localparam logic OP_ENCRYPT = 1'b1;

    localparam logic [4:0] ROT_5  = 5'd5;
    localparam logic [4:0] ROT_13 = 5'd13;
    localparam logic [4:0] ROT_21 = 5'd21;

    typedef logic [WORD_W-1:0] t_word;
    typedef t_word t_key_arr [NUM_KEY_WORDS];

    typedef struct packed {
        logic  op;
        t_word a;
        t_word b;
        t_word c;
        t_word d;
    } t_state;

    localparam logic [7:0] SBOX [256] = '{
        8'hB1, 8'h94, 8'hBA, 8'hC8, 8'h0A, 8'h08, 8'hF5, 8'h3B,
        8'h36, 8'h6D, 8'h00, 8'h8E, 8'h58, 8'h4A, 8'h5D, 8'hE4,
        8'h85, 8'h04, 8'hFA, 8'h9D, 8'h1B, 8'hB6, 8'hC7, 8'hAC,
        8'h25, 8'h2E, 8'h72, 8'hC2, 8'h02, 8'hFD, 8'hCE, 8'h0D,
        8'h5B, 8'hE3, 8'hD6, 8'h12, 8'h17, 8'hB9, 8'h61, 8'h81,
        8'hFE, 8'h67, 8'h86, 8'hAD, 8'h71, 8'h6B, 8'h89, 8'h0B,
        8'h5C, 8'hB0, 8'hC0, 8'hFF, 8'h33, 8'hC3, 8'h56, 8'hB8,
        8'h35, 8'hC4, 8'h05, 8'hAE, 8'hD8, 8'hE0, 8'h7F, 8'h99,
        8'hE1, 8'h2B, 8'hDC, 8'h1A, 8'hE2, 8'h82, 8'h57, 8'hEC,
        8'h70, 8'h3F, 8'hCC, 8'hF0, 8'h95, 8'hEE, 8'h8D, 8'hF1,
        8'hC1, 8'hAB, 8'h76, 8'h38, 8'h9F, 8'hE6, 8'h78, 8'hCA,
        8'hF7, 8'hC6, 8'hF8, 8'h60, 8'hD5, 8'hBB, 8'h9C, 8'h4F,
        8'hF3, 8'h3C, 8'h65, 8'h7B, 8'h63, 8'h7C, 8'h30, 8'h6A,
        8'hDD, 8'h4E, 8'hA7, 8'h79, 8'h9E, 8'hB2, 8'h3D, 8'h31,
        8'h3E, 8'h98, 8'hB5, 8'h6E, 8'h27, 8'hD3, 8'hBC, 8'hCF,
        8'h59, 8'h1E, 8'h18, 8'h1F, 8'h4C, 8'h5A, 8'hB7, 8'h93,
        8'hE9, 8'hDE, 8'hE7, 8'h2C, 8'h8F, 8'h0C, 8'h0F, 8'hA6,
        8'h2D, 8'hDB, 8'h49, 8'hF4, 8'h6F, 8'h73, 8'h96, 8'h47,
        8'h06, 8'h07, 8'h53, 8'h16, 8'hED, 8'h24, 8'h7A, 8'h37,
        8'h39, 8'hCB, 8'hA3, 8'h83, 8'h03, 8'hA9, 8'h8B, 8'hF6,
        8'h92, 8'hBD, 8'h9B, 8'h1C, 8'hE5, 8'hD1, 8'h41, 8'h01,
        8'h54, 8'h45, 8'hFB, 8'hC9, 8'h5E, 8'h4D, 8'h0E, 8'hF2,
        8'h68, 8'h20, 8'h80, 8'hAA, 8'h22, 8'h7D, 8'h64, 8'h2F,
        8'h26, 8'h87, 8'hF9, 8'h34, 8'h90, 8'h40, 8'h55, 8'h11,
        8'hBE, 8'h32, 8'h97, 8'h13, 8'h43, 8'hFC, 8'h9A, 8'h48,
        8'hA0, 8'h2A, 8'h88, 8'h5F, 8'h19, 8'h4B, 8'h09, 8'hA1,
        8'h7E, 8'hCD, 8'hA4, 8'hD0, 8'h15, 8'h44, 8'hAF, 8'h8C,
        8'hA5, 8'h84, 8'h50, 8'hBF, 8'h66, 8'hD2, 8'hE8, 8'h8A,
        8'hA2, 8'hD7, 8'h46, 8'h52, 8'h42, 8'hA8, 8'hDF, 8'hB3,
        8'h69, 8'h74, 8'hC5, 8'h51, 8'hEB, 8'h23, 8'h29, 8'h21,
        8'hD4, 8'hEF, 8'hD9, 8'hB4, 8'h3A, 8'h62, 8'h28, 8'h75,
        8'h91, 8'h14, 8'h10, 8'hEA, 8'h77, 8'h6C, 8'hDA, 8'h1D
    };

    // G map: S-box on each byte, then rotate left
    function automatic t_word g_map(input t_word w, input logic [4:0] rot);
        t_word                s;
        logic [2*WORD_W-1:0]  ss;
        s  = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
        ss = {s, s} << rot;
        return ss[2*WORD_W-1:WORD_W];
    endfunction

    // Key word index for G number g (1..8, 8 wraps to 0) in round slot rnd.
    // Encrypt walks the schedule forward, decrypt walks it backward.
    function automatic logic [KEY_IDX_W-1:0] key_idx(
        input logic                 op,
        input logic [KEY_IDX_W-1:0] rnd,
        input logic [KEY_IDX_W-1:0] g
    );
        logic [KEY_IDX_W-1:0] idx;
        if (op == OP_ENCRYPT) begin
            idx = g - KEY_IDX_W'(1) - rnd;
        end else begin
            idx = rnd - g;
        end
        return idx;
    endfunction

endpackage

@@ rtl/belt_block_cipher.sv @@
// belt_block_cipher: pipelined block engine for the belt cipher (8 rounds).
// Key: eight 32-bit words written through i_cfg_wr_en / i_cfg_index /
//   i_cfg_data, one word per cycle, no wait state. Write only while idle.
// Input word: i_operation (1 encrypt, 0 decrypt) and four 32-bit
//   little-endian block words, taken when i_in_valid && o_in_ready.
// Output word: four 32-bit result words, taken when o_out_valid && i_out_ready.
// Structure: each round is split into four G levels, one register stage each,
//   32 stages in all. Each stage holds two key adds and two S-box passes with
//   fixed rotates (level 3 only one) and their add/sub/xor; level 1 has the three-input add.
// Path: stage 0 loads at the accepting edge; o_out_valid comes from the last stage.
// Throughput: one block per clock with i_out_ready high.
// Stall: every stage advances when it is empty or the next stage advances,
//   so bubbles are squeezed out and input is still taken while a finished
//   result waits, until all 32 stages are full. Nothing is dropped or repeated.
// Reset (synchronous, i_rst_n low): all stages empty, key words cleared to 0.
module belt_block_cipher (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [belt_pkg::KEY_IDX_W-1:0]  i_cfg_index,
    input  logic [belt_pkg::WORD_W-1:0]     i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic                            i_operation,
    input  logic [belt_pkg::WORD_W-1:0]     i_in_word_0,
    input  logic [belt_pkg::WORD_W-1:0]     i_in_word_1,
    input  logic [belt_pkg::WORD_W-1:0]     i_in_word_2,
    input  logic [belt_pkg::WORD_W-1:0]     i_in_word_3,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [belt_pkg::WORD_W-1:0]     o_out_word_0,
    output logic [belt_pkg::WORD_W-1:0]     o_out_word_1,
    output logic [belt_pkg::WORD_W-1:0]     o_out_word_2,
    output logic [belt_pkg::WORD_W-1:0]     o_out_word_3
);

    localparam int NS = belt_pkg::NUM_STAGES;
    localparam int KW = belt_pkg::KEY_IDX_W;

    belt_pkg::t_key_arr r_key;

    belt_pkg::t_state   r_st  [NS];
    logic               r_vld [NS];
    belt_pkg::t_state   w_cur [NS];
    belt_pkg::t_state   w_nxt [NS];
    logic [NS:0]        w_adv;          // stage k may load this cycle

    // key words
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < belt_pkg::NUM_KEY_WORDS; k++) begin
                r_key[k] <= '0;
            end
        end else if (i_cfg_wr_en) begin
            r_key[i_cfg_index] <= i_cfg_data;
        end
    end

    assign w_adv[NS] = i_out_ready;
    assign o_in_ready = w_adv[0];

    for (genvar s = 0; s < NS; s++) begin : g_stage
        localparam int      LVL = s % belt_pkg::LEVELS;
        localparam logic [KW-1:0] RND = KW'(s / belt_pkg::LEVELS);
        localparam logic [KW-1:0] GX  = KW'(2 * LVL + 1);
        localparam logic [KW-1:0] GY  = KW'(2 * LVL + 2);

        belt_pkg::t_word w_kx;
        belt_pkg::t_word w_ky;
        logic            w_src_vld;

        assign w_adv[s] = !r_vld[s] || w_adv[s+1];

        if (s == 0) begin : g_src_in
            assign w_cur[s]  = '{op: i_operation, a: i_in_word_0, b: i_in_word_1,
                                 c: i_in_word_2, d: i_in_word_3};
            assign w_src_vld = i_in_valid;
        end else begin : g_src_prev
            assign w_cur[s]  = r_st[s-1];
            assign w_src_vld = r_vld[s-1];
        end

        assign w_kx = r_key[belt_pkg::key_idx(w_cur[s].op, RND, GX)];
        assign w_ky = r_key[belt_pkg::key_idx(w_cur[s].op, RND, GY)];

        case (LVL)
            0: begin : g_lvl0
                always_comb begin
                    w_nxt[s]   = w_cur[s];
                    w_nxt[s].b = w_cur[s].b
                               ^ belt_pkg::g_map(w_cur[s].a + w_kx, belt_pkg::ROT_5);
                    w_nxt[s].c = w_cur[s].c
                               ^ belt_pkg::g_map(w_cur[s].d + w_ky, belt_pkg::ROT_21);
                end
            end
            1: begin : g_lvl1
                belt_pkg::t_word w_e;
                belt_pkg::t_word w_rnum;
                // round number: forward for encrypt, backward for decrypt
                assign w_rnum = (w_cur[s].op == belt_pkg::OP_ENCRYPT)
                              ? belt_pkg::WORD_W'(RND) + belt_pkg::WORD_W'(1)
                              : belt_pkg::WORD_W'(belt_pkg::NUM_ROUNDS)
                                - belt_pkg::WORD_W'(RND);
                assign w_e = belt_pkg::g_map(w_cur[s].b + w_cur[s].c + w_ky,
                                             belt_pkg::ROT_21) ^ w_rnum;
                always_comb begin
                    w_nxt[s]   = w_cur[s];
                    w_nxt[s].a = w_cur[s].a
                               - belt_pkg::g_map(w_cur[s].b + w_kx, belt_pkg::ROT_13);
                    w_nxt[s].b = w_cur[s].b + w_e;
                    w_nxt[s].c = w_cur[s].c - w_e;
                end
            end
            2: begin : g_lvl2
                always_comb begin
                    w_nxt[s]   = w_cur[s];
                    w_nxt[s].d = w_cur[s].d
                               + belt_pkg::g_map(w_cur[s].c + w_kx, belt_pkg::ROT_13);
                    w_nxt[s].b = w_cur[s].b
                               ^ belt_pkg::g_map(w_cur[s].a + w_ky, belt_pkg::ROT_21);
                end
            end
            default: begin : g_lvl3
                belt_pkg::t_word w_c;
                // last G uses w_kx only; w_ky is the next round's first key
                assign w_c = w_cur[s].c
                           ^ belt_pkg::g_map(w_cur[s].d + w_kx, belt_pkg::ROT_5)
                           ^ (w_ky & '0);
                // end-of-round word swap
                always_comb begin
                    w_nxt[s].op = w_cur[s].op;
                    if (w_cur[s].op == belt_pkg::OP_ENCRYPT) begin
                        w_nxt[s].a = w_cur[s].b;
                        w_nxt[s].b = w_cur[s].d;
                        w_nxt[s].c = w_cur[s].a;
                        w_nxt[s].d = w_c;
                    end else begin
                        w_nxt[s].a = w_c;
                        w_nxt[s].b = w_cur[s].a;
                        w_nxt[s].c = w_cur[s].d;
                        w_nxt[s].d = w_cur[s].b;
                    end
                end
            end
        endcase

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (w_adv[s]) begin
                r_vld[s] <= w_src_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_adv[s]) begin
                r_st[s] <= w_nxt[s];
            end
        end
    end

    // output word order: same swap once more after the last round
    assign o_out_valid = r_vld[NS-1];

    always_comb begin
        if (r_st[NS-1].op == belt_pkg::OP_ENCRYPT) begin
            o_out_word_0 = r_st[NS-1].b;
            o_out_word_1 = r_st[NS-1].d;
            o_out_word_2 = r_st[NS-1].a;
            o_out_word_3 = r_st[NS-1].c;
        end else begin
            o_out_word_0 = r_st[NS-1].c;
            o_out_word_1 = r_st[NS-1].a;
            o_out_word_2 = r_st[NS-1].d;
            o_out_word_3 = r_st[NS-1].b;
        end
    end

`ifndef SYNTHESIS
    logic [NS-1:0] w_vld_vec;
    logic          w_in_acc;
    logic          w_out_acc;

    always_comb begin
        for (int k = 0; k < NS; k++) begin
            w_vld_vec[k] = r_vld[k];
        end
    end

    assign w_in_acc  = i_in_valid && o_in_ready;
    assign w_out_acc = o_out_valid && i_out_ready;

    // occupancy changes only by words taken in and words handed out
    a_occupancy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> $countones(w_vld_vec) == $past($countones(w_vld_vec))
                 + int'($past(w_in_acc)) - int'($past(w_out_acc)))
        else $error("pipeline occupancy lost or gained a word");

    // a pipeline with any empty stage must take input
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(&w_vld_vec) |-> o_in_ready)
        else $error("input stalled while a stage is empty");

    // full pipeline with stalled output must not take input
    a_ready_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (&w_vld_vec) && !i_out_ready |-> !o_in_ready)
        else $error("input taken into a full stalled pipeline");

    // the operation select travels with its word
    a_op_follow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[0] && w_adv[1] |=> r_vld[1] && r_st[1].op == $past(r_st[0].op))
        else $error("operation select lost between stages");
`endif

endmodule

@@ tb/sv/belt_block_cipher_tb.sv @@
module belt_block_cipher_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // One 128-bit block, index k holds block bytes 4k..4k+3 (little-endian word)
    typedef logic [3:0][belt_pkg::WORD_W-1:0] t_block;

    // Output-side ready patterns
    typedef enum logic [1:0] {
        RX_ALWAYS,
        RX_RANDOM,
        RX_BURSTY
    } t_rx_mode;

    // drain margin past the pipeline depth
    localparam int PIPE_LATENCY = belt_pkg::NUM_STAGES + 4;
    localparam int LONG_HOLD    = 150;              // longer than the pipe is deep
    localparam int CYCLE_LIMIT  = 200000;

    // DUT ports, every input known from time zero
    logic                               i_clk       = 1'b0;
    logic                               i_rst_n     = 1'b0;
    logic                               i_cfg_wr_en = 1'b0;
    logic [belt_pkg::KEY_IDX_W-1:0]     i_cfg_index = '0;
    belt_pkg::t_word                    i_cfg_data  = '0;
    logic                               i_in_valid  = 1'b0;
    logic                               o_in_ready;
    logic                               i_operation = belt_pkg::OP_ENCRYPT;
    belt_pkg::t_word                    i_in_word_0 = '0;
    belt_pkg::t_word                    i_in_word_1 = '0;
    belt_pkg::t_word                    i_in_word_2 = '0;
    belt_pkg::t_word                    i_in_word_3 = '0;
    logic                               o_out_valid;
    logic                               i_out_ready = 1'b0;
    belt_pkg::t_word                    o_out_word_0;
    belt_pkg::t_word                    o_out_word_1;
    belt_pkg::t_word                    o_out_word_2;
    belt_pkg::t_word                    o_out_word_3;

    // Shadow of the key registers; reset clears them
    belt_pkg::t_key_arr key_model = '{default: '0};
    // Cipher results still owed by the DUT, oldest first
    t_block         expected_blocks [$];
    int unsigned    error_count = 0;
    int unsigned    cycle_count = 0;

    // Output-side stall control
    t_rx_mode       rx_mode      = RX_ALWAYS;
    logic           hold_request = 1'b0;
    int unsigned    hold_left    = 0;
    logic           run_on       = 1'b1;
    int unsigned    run_left     = 0;

    belt_block_cipher u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_operation  (i_operation),
        .i_in_word_0  (i_in_word_0),
        .i_in_word_1  (i_in_word_1),
        .i_in_word_2  (i_in_word_2),
        .i_in_word_3  (i_in_word_3),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_word_0 (o_out_word_0),
        .o_out_word_1 (o_out_word_1),
        .o_out_word_2 (o_out_word_2),
        .o_out_word_3 (o_out_word_3)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Cipher predictor
    // ------------------------------------------------------------------

    // S-box on every byte, then rotate left
    function automatic belt_pkg::t_word sbox_rotate(input belt_pkg::t_word w,
                                                    input logic [4:0] rot);
        belt_pkg::t_word s;
        s = {belt_pkg::SBOX[w[31:24]], belt_pkg::SBOX[w[23:16]],
             belt_pkg::SBOX[w[15:8]], belt_pkg::SBOX[w[7:0]]};
        return (s << rot) | (s >> (belt_pkg::WORD_W - rot));
    endfunction

    // Round key j (counted from 1) cycles over the eight key words
    function automatic belt_pkg::t_word round_key(input int j);
        return key_model[(j - 1) % belt_pkg::NUM_KEY_WORDS];
    endfunction

    function automatic t_block belt_transform(input logic op, input t_block x);
        belt_pkg::t_word a, b, c, d, e, t;
        a = x[0];
        b = x[1];
        c = x[2];
        d = x[3];
        if (op == belt_pkg::OP_ENCRYPT) begin
            for (int i = 1; i <= belt_pkg::NUM_ROUNDS; i++) begin
                b ^= sbox_rotate(a + round_key(7*i - 6), belt_pkg::ROT_5);
                c ^= sbox_rotate(d + round_key(7*i - 5), belt_pkg::ROT_21);
                a -= sbox_rotate(b + round_key(7*i - 4), belt_pkg::ROT_13);
                e  = sbox_rotate(b + c + round_key(7*i - 3), belt_pkg::ROT_21)
                   ^ belt_pkg::t_word'(i);
                b += e;
                c -= e;
                d += sbox_rotate(c + round_key(7*i - 2), belt_pkg::ROT_13);
                b ^= sbox_rotate(a + round_key(7*i - 1), belt_pkg::ROT_21);
                c ^= sbox_rotate(d + round_key(7*i), belt_pkg::ROT_5);
                t = a; a = b; b = t;
                t = c; c = d; d = t;
                t = b; b = c; c = t;
            end
            return {c, a, d, b};        // out words 0..3 = b, d, a, c
        end else begin
            for (int i = belt_pkg::NUM_ROUNDS; i >= 1; i--) begin
                b ^= sbox_rotate(a + round_key(7*i), belt_pkg::ROT_5);
                c ^= sbox_rotate(d + round_key(7*i - 1), belt_pkg::ROT_21);
                a -= sbox_rotate(b + round_key(7*i - 2), belt_pkg::ROT_13);
                e  = sbox_rotate(b + c + round_key(7*i - 3), belt_pkg::ROT_21)
                   ^ belt_pkg::t_word'(i);
                b += e;
                c -= e;
                d += sbox_rotate(c + round_key(7*i - 4), belt_pkg::ROT_13);
                b ^= sbox_rotate(a + round_key(7*i - 5), belt_pkg::ROT_21);
                c ^= sbox_rotate(d + round_key(7*i - 6), belt_pkg::ROT_5);
                t = a; a = b; b = t;
                t = c; c = d; d = t;
                t = a; a = d; d = t;
            end
            return {b, d, a, c};        // out words 0..3 = c, a, d, b
        end
    endfunction

    // Mostly uniform, with the all-zero and all-one words mixed in
    function automatic belt_pkg::t_word rand_word();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return $urandom();
        endcase
    endfunction

    function automatic t_block rand_block();
        t_block blk;
        foreach (blk[k]) blk[k] = rand_word();
        return blk;
    endfunction

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    // Offer one word and hold it until taken; the result is owed from then on.
    // Called at a clock edge; valid stays high into the next call.
    task automatic send_block(input logic op, input t_block blk);
        i_in_valid  <= 1'b1;
        i_operation <= op;
        i_in_word_0 <= blk[0];
        i_in_word_1 <= blk[1];
        i_in_word_2 <= blk[2];
        i_in_word_3 <= blk[3];
        do @(posedge i_clk); while (!(i_in_valid && o_in_ready));
        expected_blocks.push_back(belt_transform(op, blk));
    endtask

    // Sender gap; n must be at least one so valid is not lowered and raised at one edge
    task automatic pause_sender(input int unsigned n);
        i_in_valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // Random words, in bursts with gaps between them or back to back
    task automatic send_stream(input int n, input bit with_gaps);
        int unsigned burst_left;
        burst_left = $urandom_range(1, 16);
        for (int k = 0; k < n; k++) begin
            send_block(logic'($urandom_range(0, 1)), rand_block());
            if (with_gaps) begin
                burst_left--;
                if (burst_left == 0) begin
                    pause_sender($urandom_range(1, 8));
                    burst_left = $urandom_range(1, 16);
                end
            end
        end
    endtask

    // Stop offering, wait for every owed result, then let the pipe settle
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (expected_blocks.size() != 0) @(posedge i_clk);
        repeat (PIPE_LATENCY) @(posedge i_clk);
    endtask

    // Write all eight key words on consecutive edges; only while idle
    task automatic load_key(input belt_pkg::t_key_arr key);
        for (int k = 0; k < belt_pkg::NUM_KEY_WORDS; k++) begin
            i_cfg_wr_en <= 1'b1;
            i_cfg_index <= belt_pkg::KEY_IDX_W'(k);
            i_cfg_data  <= key[k];
            @(posedge i_clk);
            key_model[k] = key[k];
        end
        i_cfg_wr_en <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Output side
    // ------------------------------------------------------------------

    // Ready pattern, plus a long hold when a test asks for one
    always @(posedge i_clk) begin : out_ready_gen
        if (hold_request) begin
            hold_left    = LONG_HOLD;
            hold_request = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            case (rx_mode)
                RX_ALWAYS: begin
                    i_out_ready <= 1'b1;
                end
                RX_RANDOM: begin
                    i_out_ready <= ($urandom_range(0, 3) != 0);
                end
                default: begin
                    // alternating on/off runs of random length
                    if (run_left == 0) begin
                        run_on   = !run_on;
                        run_left = run_on ? $urandom_range(1, 12) : $urandom_range(1, 6);
                    end else begin
                        run_left--;
                    end
                    i_out_ready <= run_on;
                end
            endcase
        end
    end

    // Compare every taken result word with the oldest owed one
    always @(posedge i_clk) begin : result_check
        t_block got;
        t_block want;
        got = {o_out_word_3, o_out_word_2, o_out_word_1, o_out_word_0};
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_blocks.size() == 0) begin
                $display("%0t: result with none owed, expected none, actual %h", $time, got);
                error_count++;
            end else begin
                want = expected_blocks.pop_front();
                for (int k = 0; k < 4; k++) begin
                    if (got[k] !== want[k]) begin
                        $display("%0t: out_word_%0d expected %08h actual %08h",
                                 $time, k, want[k], got[k]);
                        error_count++;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Key left at its reset value of zero; both directions, extreme blocks
    task automatic test_reset_key();
        rx_mode = RX_RANDOM;
        send_block(belt_pkg::OP_ENCRYPT, '0);
        send_block(belt_pkg::OP_DECRYPT, '0);
        send_block(belt_pkg::OP_ENCRYPT, '1);
        send_block(belt_pkg::OP_DECRYPT, '1);
        send_block(belt_pkg::OP_ENCRYPT, {4{32'h5555_5555}});
        send_block(belt_pkg::OP_DECRYPT, {4{32'hAAAA_AAAA}});
        wait_idle();
    endtask

    // All-ones and alternating keys, single-bit blocks, decrypt of a ciphertext
    task automatic test_key_extremes();
        belt_pkg::t_key_arr key;
        t_block             plain;
        key = '{default: '1};
        load_key(key);
        send_block(belt_pkg::OP_ENCRYPT, {32'h0, 32'h0, 32'h0, 32'h0000_0001});
        send_block(belt_pkg::OP_ENCRYPT, {32'h8000_0000, 32'h0, 32'h0, 32'h0});
        send_block(belt_pkg::OP_DECRYPT, {32'h0, 32'h0000_0001, 32'h8000_0000, 32'h0});
        send_block(belt_pkg::OP_DECRYPT, '1);
        send_block(belt_pkg::OP_ENCRYPT, '1);
        send_block(belt_pkg::OP_DECRYPT, '0);
        wait_idle();

        foreach (key[k]) key[k] = (k % 2) ? 32'hAAAA_AAAA : 32'h5555_5555;
        load_key(key);
        plain = rand_block();
        send_block(belt_pkg::OP_ENCRYPT, plain);
        // should come back as the plaintext
        send_block(belt_pkg::OP_DECRYPT, belt_transform(belt_pkg::OP_ENCRYPT, plain));
        send_block(belt_pkg::OP_ENCRYPT, {32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h0});
        send_block(belt_pkg::OP_DECRYPT, {32'h0, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF});
        send_block(belt_pkg::OP_ENCRYPT,
                   {32'h7FFF_FFFF, 32'hFFFF_FFFE, 32'h0000_0001, 32'h8000_0000});
        send_block(belt_pkg::OP_DECRYPT,
                   {32'h7FFF_FFFF, 32'hFFFF_FFFE, 32'h0000_0001, 32'h8000_0000});
        wait_idle();
    endtask

    // Random traffic under several keys, last one mixing zero and all-ones words
    task automatic test_random_keys();
        belt_pkg::t_key_arr key;
        for (int phase = 0; phase < 4; phase++) begin
            foreach (key[k]) key[k] = (phase == 3) ? ((k % 2) ? '1 : '0) : $urandom();
            load_key(key);
            rx_mode = (phase % 2) ? RX_BURSTY : RX_RANDOM;
            send_stream(220, 1'b1);
            wait_idle();
        end
    endtask

    // Full rate: no sender gaps, no receiver stalls
    task automatic test_streaming();
        rx_mode = RX_ALWAYS;
        send_stream(100, 1'b0);
        wait_idle();
    endtask

    // Receiver holds off long enough for all stages to fill and input to stall
    task automatic test_backpressure();
        rx_mode      = RX_RANDOM;
        hold_request = 1'b1;
        send_stream(90, 1'b0);
        wait_idle();
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_key();
        test_key_extremes();
        test_random_keys();
        test_streaming();
        test_backpressure();
        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Some tests failed");
        $finish;
    end

endmodule
